// ===== hdl/teom_pkg.sv =====
// teom_pkg: shared types, constants and helpers for the touch event orientation mapper
// depends on nothing; used by touch_event_orientation_mapper
`timescale 1ns / 1ps

package teom_pkg;

   // width of a held coordinate, two's complement
   localparam int COORD_BITS = 16;
   // width of one event value beat
   localparam int VALUE_BITS = 16;
   // width of a display resolution and of a mapped point axis
   localparam int RES_BITS   = 15;
   // wide enough for a coordinate and two subtractions from a resolution
   localparam int CALC_BITS  = ((COORD_BITS > VALUE_BITS) ? COORD_BITS : VALUE_BITS) + 3;
   // width of the value handed to the coordinate fit, at least the coordinate and value widths
   localparam int FIT_BITS   = (COORD_BITS > VALUE_BITS) ? COORD_BITS : VALUE_BITS;

   localparam logic [RES_BITS-1:0] WIDTH_RESET  = RES_BITS'(320);
   localparam logic [RES_BITS-1:0] HEIGHT_RESET = RES_BITS'(240);

   typedef enum logic [2:0] {
      CSR_SWAP_AXES     = 3'd0,
      CSR_MIRROR_X      = 3'd1,
      CSR_MIRROR_Y      = 3'd2,
      CSR_ORIENTATION   = 3'd3,
      CSR_WIDTH_PIXELS  = 3'd4,
      CSR_HEIGHT_PIXELS = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_ABS_X  = 2'd0,
      EV_ABS_Y  = 2'd1,
      EV_BUTTON = 2'd2,
      EV_OTHER  = 2'd3
   } event_code_type;

   typedef enum logic [1:0] {
      ORIENT_0   = 2'd0,
      ORIENT_90  = 2'd1,
      ORIENT_180 = 2'd2,
      ORIENT_270 = 2'd3
   } orientation_type;

   // event value sign-extended, then cut to the held coordinate width
   function automatic logic signed [COORD_BITS-1:0] fit_coord(
      input logic [VALUE_BITS-1:0] raw
   );
      logic signed [FIT_BITS-1:0] ext;
      ext = FIT_BITS'($signed(raw));
      return ext[COORD_BITS-1:0];
   endfunction

   // held coordinate widened to the calculation width
   function automatic logic signed [CALC_BITS-1:0] widen_coord(
      input logic signed [COORD_BITS-1:0] c
   );
      return CALC_BITS'(c);
   endfunction

   // resolution widened to the calculation width, never negative
   function automatic logic signed [CALC_BITS-1:0] widen_res(
      input logic [RES_BITS-1:0] r
   );
      return $signed({{(CALC_BITS-RES_BITS){1'b0}}, r});
   endfunction

   // clamp into 0..res-1, a zero resolution gives 0
   function automatic logic [RES_BITS-1:0] clamp_axis(
      input logic signed [CALC_BITS-1:0] v,
      input logic [RES_BITS-1:0]         res
   );
      logic [RES_BITS-1:0] result;
      if (v <= $signed(CALC_BITS'(0))) begin
         result = '0;
      end else if (v >= widen_res(res)) begin
         result = (res != '0) ? RES_BITS'(res - RES_BITS'(1)) : '0;
      end else begin
         result = v[RES_BITS-1:0];
      end
      return result;
   endfunction

endpackage

// ===== hdl/touch_event_orientation_mapper.sv =====
// touch_event_orientation_mapper: latches touch events and emits mapped display points
// depends on teom_pkg (types, constants, coordinate and clamp helpers)
`timescale 1ns / 1ps

// Touch events enter on the req_ channel, one beat per event: an event code
// (absolute X, absolute Y, touch button, other), a signed value and a sync mark.
// Each beat is taken into an input register; when it leaves there it updates the
// latched X, Y and pressed state, and a beat with the sync mark also loads the
// result register with one mapped point (swap, mirror, rotate, clamp) built from
// the state that includes the beat itself. That point leaves on the rsp_ channel.
// Throughput: one beat per cycle while req_stall is low; the input register and the
// result register part the two channels, so a beat is taken while a point still waits.
// When the receiver holds rsp_stall, the point stays in the result register; beats
// without the sync mark still pass into the latched state, and the next sync beat
// waits in the input register, which then raises req_stall.
// Reset (synchronous, active high) clears the latched state to zero and released,
// empties both registers and loads the configuration defaults (320 by 240, upright).
// csr_ writes one register per edge; the user must write only while idle, unenforced.
module touch_event_orientation_mapper (
   input  logic                               clock,
   input  logic                               reset,
   // event beats
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_event_code,
   input  logic signed [teom_pkg::VALUE_BITS-1:0] req_event_value,
   input  logic                               req_sync_mark,
   // mapped points
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [teom_pkg::RES_BITS-1:0]      rsp_point_x,
   output logic [teom_pkg::RES_BITS-1:0]      rsp_point_y,
   output logic                               rsp_touch_pressed,
   // configuration writes
   input  logic                               csr_write,
   input  logic [2:0]                         csr_index,
   input  logic [teom_pkg::RES_BITS-1:0]      csr_data
);

   // configuration registers
   logic                              swap_axes_ff;
   logic                              mirror_x_ff;
   logic                              mirror_y_ff;
   logic [1:0]                        orientation_ff;
   logic [teom_pkg::RES_BITS-1:0]     width_ff;
   logic [teom_pkg::RES_BITS-1:0]     height_ff;

   // input register
   logic                              s1_valid_ff, s1_valid_in;
   logic [1:0]                        s1_code_ff;
   logic [teom_pkg::VALUE_BITS-1:0]   s1_value_ff;
   logic                              s1_sync_ff;

   // latched touch state
   logic signed [teom_pkg::COORD_BITS-1:0] held_x_ff, held_x_in;
   logic signed [teom_pkg::COORD_BITS-1:0] held_y_ff, held_y_in;
   logic                                   held_pressed_ff, held_pressed_in;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [teom_pkg::RES_BITS-1:0]     point_x_ff, point_x_in;
   logic [teom_pkg::RES_BITS-1:0]     point_y_ff, point_y_in;
   logic                              pressed_ff;

   logic out_free;
   logic s1_go;
   logic req_accept;

   // transform datapath
   logic signed [teom_pkg::CALC_BITS-1:0] wide_w, wide_h;
   logic signed [teom_pkg::CALC_BITS-1:0] sx, sy, mx, my, rx, ry;
   logic                                  upright;

   // handshake control
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_go      = s1_valid_ff && (!s1_sync_ff || out_free);
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_go && s1_sync_ff) ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   // configuration write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         swap_axes_ff   <= 1'b0;
         mirror_x_ff    <= 1'b0;
         mirror_y_ff    <= 1'b0;
         orientation_ff <= teom_pkg::ORIENT_0;
         width_ff       <= teom_pkg::WIDTH_RESET;
         height_ff      <= teom_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            teom_pkg::CSR_SWAP_AXES:     swap_axes_ff   <= csr_data[0];
            teom_pkg::CSR_MIRROR_X:      mirror_x_ff    <= csr_data[0];
            teom_pkg::CSR_MIRROR_Y:      mirror_y_ff    <= csr_data[0];
            teom_pkg::CSR_ORIENTATION:   orientation_ff <= csr_data[1:0];
            teom_pkg::CSR_WIDTH_PIXELS:  width_ff       <= csr_data;
            teom_pkg::CSR_HEIGHT_PIXELS: height_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // next latched state from the beat leaving the input register
   always_comb begin
      held_x_in       = held_x_ff;
      held_y_in       = held_y_ff;
      held_pressed_in = held_pressed_ff;
      if (s1_go) begin
         case (s1_code_ff)
            teom_pkg::EV_ABS_X:  held_x_in       = teom_pkg::fit_coord(s1_value_ff);
            teom_pkg::EV_ABS_Y:  held_y_in       = teom_pkg::fit_coord(s1_value_ff);
            teom_pkg::EV_BUTTON: held_pressed_in = (s1_value_ff != '0);
            default: ;
         endcase
      end
   end

   // swap, mirror, rotate and clamp from the updated state
   always_comb begin
      wide_w  = teom_pkg::widen_res(width_ff);
      wide_h  = teom_pkg::widen_res(height_ff);
      upright = (orientation_ff == teom_pkg::ORIENT_0) ||
                (orientation_ff == teom_pkg::ORIENT_180);
      sx = swap_axes_ff ? teom_pkg::widen_coord(held_y_in) : teom_pkg::widen_coord(held_x_in);
      sy = swap_axes_ff ? teom_pkg::widen_coord(held_x_in) : teom_pkg::widen_coord(held_y_in);
      mx = mirror_x_ff ? ((upright ? wide_w : wide_h) - sx) : sx;
      my = mirror_y_ff ? ((upright ? wide_h : wide_w) - sy) : sy;
      case (orientation_ff)
         teom_pkg::ORIENT_90: begin
            rx = my;
            ry = wide_h - mx;
         end
         teom_pkg::ORIENT_180: begin
            rx = wide_w - mx;
            ry = wide_h - my;
         end
         teom_pkg::ORIENT_270: begin
            rx = wide_w - my;
            ry = mx;
         end
         default: begin
            rx = mx;
            ry = my;
         end
      endcase
      point_x_in = teom_pkg::clamp_axis(rx, width_ff);
      point_y_in = teom_pkg::clamp_axis(ry, height_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         held_x_ff       <= '0;
         held_y_ff       <= '0;
         held_pressed_ff <= 1'b0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         held_x_ff       <= held_x_in;
         held_y_ff       <= held_y_in;
         held_pressed_ff <= held_pressed_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_code_ff  <= req_event_code;
         s1_value_ff <= req_event_value;
         s1_sync_ff  <= req_sync_mark;
      end
      if (s1_go && s1_sync_ff) begin
         point_x_ff <= point_x_in;
         point_y_ff <= point_y_in;
         pressed_ff <= held_pressed_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_point_x       = point_x_ff;
   assign rsp_point_y       = point_y_ff;
   assign rsp_touch_pressed = pressed_ff;

   // a mapped point stays inside the display
   a_point_x_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (width_ff != '0) |-> (point_x_ff < width_ff))
      else $error("point_x outside display width");

   a_point_y_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (height_ff != '0) |-> (point_y_ff < height_ff))
      else $error("point_y outside display height");

   // input side only stalls on a waiting sync beat
   a_stall_needs_sync: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_sync_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked sync beat");

   // a sync beat leaving the input register shows up as a point
   a_sync_gives_point: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_sync_ff |=> rsp_valid_ff)
      else $error("sync beat produced no point");

   // a beat without the sync mark never loads a point
   a_plain_beat_no_point: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !(s1_go && s1_sync_ff) |=> !rsp_valid_ff)
      else $error("point appeared without a sync beat");

endmodule
